/* design/ist_pkg.sv */
`default_nettype none

package ist_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] value;
        logic [5:0]         index;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic [5:0]         position;
        logic signed [31:0] read_data;
        logic [6:0]         count;
        logic [1:0]         status;
    } t_out_word;

endpackage

`default_nettype wire

/* design/integer_set_table_unit.sv */
// Channel | Direction | Handshake                  | Word
// in      | input     | i_in_valid / o_in_stall    | i_in_word  (t_in_word)
// out     | output    | o_out_valid / i_out_stall  | o_out_word (t_out_word)
//
// One command at a time. A read goes through S_READ to S_DONE; out of range, straight to S_DONE.
// Insert, find and remove search the entry memory one address per cycle, stopping
// at a hit or after the last of the count entries.
// A remove hit at p then moves the later entries down one per cycle, up to the
// last entry. Reset empties the table, not the memory.
// A result held by i_out_stall waits in the output register while the next runs.
`default_nettype none

module integer_set_table_unit
    import ist_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_ptr;
    logic               r_chk_valid;
    logic [AW-1:0]      r_chk_idx;
    logic               r_found;
    logic [AW-1:0]      r_pos;
    logic signed [31:0] r_data;
    logic [1:0]         r_status;

    logic               in_acc;
    logic               out_free;
    logic               issue;
    logic               match;
    logic               search_end;
    logic               in_range;
    logic [XW-1:0]      idx_x;
    logic [XW-1:0]      cnt_x;
    logic [XW-1:0]      pos_x;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !o_out_valid || !i_out_stall;

    always_comb begin
        idx_x      = XW'(i_in_word.index);
        cnt_x      = XW'(r_count);
        pos_x      = XW'(r_pos);
        in_range   = (idx_x < cnt_x);
        issue      = (r_ptr < r_count);
        match      = r_chk_valid && (mem_rdata == r_value);
        search_end = !r_chk_valid && !issue;
        mem_raddr  = (r_state == S_IDLE) ? idx_x[AW-1:0] : r_ptr[AW-1:0];
        mem_we     = 1'b0;
        mem_waddr  = r_count[AW-1:0];
        mem_wdata  = r_value;
        case (r_state)
            S_SEARCH: begin
                mem_we = !match && search_end && (r_cmd == CMD_INSERT) &&
                         (r_count < CW'(CAPACITY));
            end
            S_SHIFT: begin
                mem_we    = r_chk_valid;
                mem_waddr = r_chk_idx - AW'(1);
                mem_wdata = mem_rdata;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    ist_ram #(
        .DEPTH (CAPACITY),
        .DW    (32),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_chk_valid <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd       <= i_in_word.command;
                        r_value     <= i_in_word.value;
                        r_ptr       <= '0;
                        r_chk_valid <= 1'b0;
                        r_found     <= 1'b0;
                        r_pos       <= '0;
                        r_data      <= '0;
                        r_status    <= ST_OK;
                        if (i_in_word.command == CMD_READ) begin
                            if (in_range) begin
                                r_state <= S_READ;
                            end else begin
                                r_status <= ST_RANGE;
                                r_state  <= S_DONE;
                            end
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_READ: begin
                    r_data  <= mem_rdata;
                    r_state <= S_DONE;
                end
                S_SEARCH: begin
                    r_chk_valid <= issue;
                    r_chk_idx   <= r_ptr[AW-1:0];
                    if (issue) begin
                        r_ptr <= r_ptr + CW'(1);
                    end
                    if (match) begin
                        r_found <= 1'b1;
                        r_pos   <= r_chk_idx;
                        if (r_cmd == CMD_REMOVE) begin
                            r_ptr       <= CW'(r_chk_idx) + CW'(1);
                            r_chk_valid <= 1'b0;
                            r_state     <= S_SHIFT;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else if (search_end) begin
                        if (r_cmd == CMD_INSERT) begin
                            if (r_count < CW'(CAPACITY)) begin
                                r_count <= r_count + CW'(1);
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                        r_state <= S_DONE;
                    end
                end
                S_SHIFT: begin
                    r_chk_valid <= issue;
                    r_chk_idx   <= r_ptr[AW-1:0];
                    if (issue) begin
                        r_ptr <= r_ptr + CW'(1);
                    end
                    if (search_end) begin
                        r_count <= r_count - CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid          <= 1'b1;
                        o_out_word.found     <= r_found;
                        o_out_word.position  <= pos_x[5:0];
                        o_out_word.read_data <= r_data;
                        o_out_word.count     <= cnt_x[6:0];
                        o_out_word.status    <= r_status;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("second command taken while one is in flight");

    a_shift_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_found && (r_cmd == CMD_REMOVE)))
        else $error("shift without a remove hit");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_count == $past(r_count)))
        else $error("count moved while idle");

    a_write_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_SEARCH) || (r_state == S_SHIFT)))
        else $error("memory write outside search or shift");

endmodule

`default_nettype wire

/* design/ist_ram.sv */
`default_nettype none

module ist_ram #(
    parameter int DEPTH = 64,
    parameter int DW    = 32,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
